// ===== hdl/kbdfifo_pkg.sv =====
// Shared types, constants and scancode table for the keyboard character queue.
package kbdfifo_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 256;

  localparam logic [7:0] STATUS_MASK  = 8'h21;
  localparam logic [7:0] STATUS_READY = 8'h01;
  localparam logic [7:0] KEYMAP_LEN   = 8'd58;

  localparam int unsigned CHAR_W = 7;

  typedef enum logic {
    ACT_EVENT = 1'b0,
    ACT_READ  = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    OUT_QUEUED     = 3'd0,
    OUT_NOT_READY  = 3'd1,
    OUT_UNMAPPED   = 3'd2,
    OUT_DROPPED    = 3'd3,
    OUT_READ_OK    = 3'd4,
    OUT_READ_EMPTY = 3'd5
  } outcome_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic execute;
  } kbd_cmd_t;

  // US scancode set 1, make codes 0 to 57
  function automatic logic [CHAR_W-1:0] keymap(input logic [5:0] code);
    logic [CHAR_W-1:0] ch;
    unique case (code)
      6'd1:    ch = 7'h1B;
      6'd2:    ch = 7'h31;
      6'd3:    ch = 7'h32;
      6'd4:    ch = 7'h33;
      6'd5:    ch = 7'h34;
      6'd6:    ch = 7'h35;
      6'd7:    ch = 7'h36;
      6'd8:    ch = 7'h37;
      6'd9:    ch = 7'h38;
      6'd10:   ch = 7'h39;
      6'd11:   ch = 7'h30;
      6'd12:   ch = 7'h2D;
      6'd13:   ch = 7'h3D;
      6'd14:   ch = 7'h08;
      6'd15:   ch = 7'h09;
      6'd16:   ch = 7'h71;
      6'd17:   ch = 7'h77;
      6'd18:   ch = 7'h65;
      6'd19:   ch = 7'h72;
      6'd20:   ch = 7'h74;
      6'd21:   ch = 7'h79;
      6'd22:   ch = 7'h75;
      6'd23:   ch = 7'h69;
      6'd24:   ch = 7'h6F;
      6'd25:   ch = 7'h70;
      6'd26:   ch = 7'h5B;
      6'd27:   ch = 7'h5D;
      6'd28:   ch = 7'h0A;
      6'd30:   ch = 7'h61;
      6'd31:   ch = 7'h73;
      6'd32:   ch = 7'h64;
      6'd33:   ch = 7'h66;
      6'd34:   ch = 7'h67;
      6'd35:   ch = 7'h68;
      6'd36:   ch = 7'h6A;
      6'd37:   ch = 7'h6B;
      6'd38:   ch = 7'h6C;
      6'd39:   ch = 7'h3B;
      6'd40:   ch = 7'h27;
      6'd41:   ch = 7'h60;
      6'd43:   ch = 7'h5C;
      6'd44:   ch = 7'h7A;
      6'd45:   ch = 7'h78;
      6'd46:   ch = 7'h63;
      6'd47:   ch = 7'h76;
      6'd48:   ch = 7'h62;
      6'd49:   ch = 7'h6E;
      6'd50:   ch = 7'h6D;
      6'd51:   ch = 7'h2C;
      6'd52:   ch = 7'h2E;
      6'd53:   ch = 7'h2F;
      6'd55:   ch = 7'h2A;
      6'd57:   ch = 7'h20;
      default: ch = '0;
    endcase
    return ch;
  endfunction

endpackage

// ===== hdl/keyboard_scancode_ascii_fifo_top.sv =====
// Keyboard scancode to ASCII character queue, top level.
// A result is presented in the result state, after the execute state that follows the
// input transfer. The controller walks accept, execute and result states per item,
// one item at a time; the result state holds until the output is accepted.
// Reset: asynchronous, clears state machine and queue pointers; memory is not cleared.
module keyboard_scancode_ascii_fifo_top
  import kbdfifo_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,  // [7:0] ctrl_status, [15:8] scan_byte
  input  logic [0:0]  s_axis_tuser_i,  // [0] action
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,  // [6:0] character, [7] zero
  output logic [3:0]  m_axis_tuser_o   // [0] char_valid, [3:1] outcome
);

  kbd_cmd_t          cmd;
  logic [CHAR_W-1:0] character;
  logic              char_valid;
  logic [2:0]        outcome;

  kbdfifo_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .cmd_o     (cmd)
  );

  kbdfifo_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .action_i      (s_axis_tuser_i[0]),
    .ctrl_status_i (s_axis_tdata_i[7:0]),
    .scan_byte_i   (s_axis_tdata_i[15:8]),
    .character_o   (character),
    .char_valid_o  (char_valid),
    .outcome_o     (outcome)
  );

  assign m_axis_tdata_o = {1'b0, character};
  assign m_axis_tuser_o = {outcome, char_valid};

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("input ready while result pending");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |-> ##2 m_axis_tvalid_o)
    else $error("result not presented two cycles after transfer");

  a_valid_means_read_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tuser_o[0] == (m_axis_tuser_o[3:1] == OUT_READ_OK)))
    else $error("char_valid disagrees with outcome");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |-> (m_axis_tdata_o == 8'h00))
    else $error("character nonzero without char_valid");

endmodule

// ===== hdl/kbdfifo_ctrl.sv =====
// Controller state machine: accept, execute, present result.
module kbdfifo_ctrl
  import kbdfifo_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     s_valid_i,
  output logic     s_ready_o,
  output logic     m_valid_o,
  input  logic     m_ready_i,
  output kbd_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_ready_o     = 1'b0;
    m_valid_o     = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_OUT;
      end
      ST_OUT: begin
        m_valid_o = 1'b1;
        if (m_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/kbdfifo_dp.sv =====
// Datapath: input capture, scancode decode, ring pointers, character memory, result registers.
module kbdfifo_dp
  import kbdfifo_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kbd_cmd_t          cmd_i,
  input  logic              action_i,
  input  logic [7:0]        ctrl_status_i,
  input  logic [7:0]        scan_byte_i,
  output logic [CHAR_W-1:0] character_o,
  output logic              char_valid_o,
  output logic [2:0]        outcome_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PtrW-1:0] PtrLast = PtrW'(QUEUE_DEPTH - 1);

  logic              action_q;
  logic [7:0]        status_q;
  logic [7:0]        scan_q;
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CHAR_W-1:0] mem_q [QUEUE_DEPTH];
  logic [CHAR_W-1:0] rd_data_q;
  logic              valid_q;
  outcome_e          outcome_q, outcome_d;

  logic [PtrW-1:0]   wr_next, rd_next;
  logic [CHAR_W-1:0] mapped_ch;
  logic              empty, full, ctl_ready, mapped;
  logic              do_push, do_pop;

  assign wr_next   = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
  assign rd_next   = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
  assign empty     = (wr_ptr_q == rd_ptr_q);
  assign full      = (wr_next == rd_ptr_q);
  assign ctl_ready = ((status_q & STATUS_MASK) == STATUS_READY);
  assign mapped_ch = keymap(scan_q[5:0]);
  assign mapped    = !scan_q[7] && (scan_q < KEYMAP_LEN) && (mapped_ch != '0);

  always_comb begin
    if (action_q == ACT_READ) begin
      outcome_d = empty ? OUT_READ_EMPTY : OUT_READ_OK;
    end else if (!ctl_ready) begin
      outcome_d = OUT_NOT_READY;
    end else if (!mapped) begin
      outcome_d = OUT_UNMAPPED;
    end else if (full) begin
      outcome_d = OUT_DROPPED;
    end else begin
      outcome_d = OUT_QUEUED;
    end
  end

  assign do_push = cmd_i.execute && (outcome_d == OUT_QUEUED);
  assign do_pop  = cmd_i.execute && (outcome_d == OUT_READ_OK);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      status_q <= ctrl_status_i;
      scan_q   <= scan_byte_i;
    end
    if (cmd_i.execute) begin
      outcome_q <= outcome_d;
      valid_q   <= (outcome_d == OUT_READ_OK);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      if (do_push) wr_ptr_q <= wr_next;
      if (do_pop)  rd_ptr_q <= rd_next;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= mapped_ch;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      rd_data_q <= mem_q[rd_ptr_q];
    end
  end

  assign character_o  = valid_q ? rd_data_q : '0;
  assign char_valid_o = valid_q;
  assign outcome_o    = outcome_q;

endmodule
